FILE: rtl/core/usp_pkg.sv
package usp_pkg;

    localparam int POS_BITS = 16;

    typedef logic [POS_BITS-1:0] t_pos;

    localparam t_pos POS_MAX = '1;

    // byte classes
    localparam logic [2:0] CLS_SCHEME = 3'd0;
    localparam logic [2:0] CLS_DELIM  = 3'd1;
    localparam logic [2:0] CLS_AUTH   = 3'd2;
    localparam logic [2:0] CLS_PATH   = 3'd3;
    localparam logic [2:0] CLS_QUERY  = 3'd4;
    localparam logic [2:0] CLS_FRAG   = 3'd5;

    // error codes, lower code wins except too long
    localparam logic [4:0] ERR_NONE        = 5'd0;
    localparam logic [4:0] ERR_SPACE       = 5'd1;
    localparam logic [4:0] ERR_NO_SCHEME   = 5'd2;
    localparam logic [4:0] ERR_EMPTY_SCH   = 5'd3;
    localparam logic [4:0] ERR_SCH_FIRST   = 5'd4;
    localparam logic [4:0] ERR_SCH_CHAR    = 5'd5;
    localparam logic [4:0] ERR_NO_SLASHES  = 5'd6;
    localparam logic [4:0] ERR_EMPTY_AUTH  = 5'd7;
    localparam logic [4:0] ERR_USERINFO    = 5'd8;
    localparam logic [4:0] ERR_OPEN_BRK    = 5'd9;
    localparam logic [4:0] ERR_EMPTY_HOST  = 5'd10;
    localparam logic [4:0] ERR_AFTER_BRK   = 5'd11;
    localparam logic [4:0] ERR_EMPTY_PORT  = 5'd12;
    localparam logic [4:0] ERR_PORT_CHAR   = 5'd13;
    localparam logic [4:0] ERR_PORT_RANGE  = 5'd14;
    localparam logic [4:0] ERR_PORT_ZERO   = 5'd15;
    localparam logic [4:0] ERR_TOO_LONG    = 5'd16;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_HTTP  = 2'd1;
    localparam logic [1:0] KIND_HTTPS = 2'd2;

    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [16:0] PORT_MAX   = 17'd65535;
    localparam logic [16:0] PORT_OVER  = 17'd65536;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef struct packed {
        logic       step;
        logic [7:0] ch;
        t_pos       pos;
        logic       feed;
        logic       start;
        logic       clear;
        t_pos       fin_end;
    } t_auth_ctl;

    typedef struct packed {
        logic [4:0]  code;
        logic        given;
        t_pos        first;
        t_pos        count;
        logic [15:0] port;
    } t_auth_res;

    typedef struct packed {
        logic [7:0] lower;
        logic       bad_first;
        logic       bad_char;
        logic [1:0] match;
    } t_scheme_info;

    function automatic logic [7:0] https_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h68;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h70;
            3'd4:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] first_error(input logic [15:0] flags);
        logic [4:0] code;
        code = ERR_NONE;
        for (int k = 15; k >= 1; k--) begin
            if (flags[k]) begin
                code = 5'(k);
            end
        end
        if (flags[0]) begin
            code = ERR_TOO_LONG;
        end
        return code;
    endfunction

endpackage

FILE: rtl/core/usp_scheme.sv
module usp_scheme (
    input  logic [7:0]            i_ch,
    input  usp_pkg::t_pos         i_pos,
    input  logic [1:0]            i_match,
    output usp_pkg::t_scheme_info o_info
);
    import usp_pkg::*;

    logic [7:0] lower;
    logic       alpha;
    logic       digit;
    logic       keep_http;
    logic       keep_https;

    always_comb begin
        lower = ((i_ch >= CH_UA) && (i_ch <= CH_UZ)) ? i_ch + CASE_GAP : i_ch;
        alpha = (lower >= CH_LA) && (lower <= CH_LZ);
        digit = (i_ch >= CH_0) && (i_ch <= CH_9);
        keep_http  = (i_pos < t_pos'(4)) && (lower == https_char(i_pos[2:0]));
        keep_https = (i_pos < t_pos'(5)) && (lower == https_char(i_pos[2:0]));

        o_info.lower     = lower;
        o_info.bad_first = (i_pos == '0) && !alpha;
        o_info.bad_char  = !(alpha || digit) && (i_ch != CH_PLUS) && (i_ch != CH_MINUS)
                           && (i_ch != CH_DOT);
        o_info.match     = {i_match[1] & keep_https, i_match[0] & keep_http};
    end

endmodule

FILE: rtl/core/usp_authority.sv
module usp_authority (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  usp_pkg::t_auth_ctl i_ctl,
    output usp_pkg::t_auth_res o_res
);
    import usp_pkg::*;

    typedef enum logic [2:0] {
        BR_NONE,
        BR_OPEN,
        BR_CLOSED,
        BR_PORT,
        BR_BAD
    } t_br;

    typedef struct packed {
        logic active;
        logic empty;
        logic nondigit;
        logic range;
    } t_seg;

    t_br         r_br,     n_br;
    t_seg        r_seg,    n_seg;
    logic [16:0] r_accum,  n_accum;
    t_pos        r_start,  n_start;
    t_pos        r_colon,  n_colon;
    logic        r_cvalid, n_cvalid;
    logic        r_at,     n_at;

    logic [20:0] prod;
    logic [4:0]  pcode;
    t_pos        len;

    always_comb begin
        n_br     = r_br;
        n_seg    = r_seg;
        n_accum  = r_accum;
        n_start  = r_start;
        n_colon  = r_colon;
        n_cvalid = r_cvalid;
        n_at     = r_at;
        prod     = {4'd0, r_accum} * 21'd10 + {13'd0, i_ctl.ch - CH_0};

        if (i_ctl.feed) begin
            if (i_ctl.ch == CH_AT) begin
                n_at = 1'b1;
            end
            if ((i_ctl.pos == r_start) && (i_ctl.ch == CH_LBRK)) begin
                n_br = BR_OPEN;
            end else begin
                case (r_br)
                    BR_NONE, BR_PORT: begin
                        if ((r_br == BR_NONE) && (i_ctl.ch == CH_COLON)) begin
                            n_cvalid = 1'b1;
                            n_colon  = i_ctl.pos;
                            n_accum  = '0;
                            n_seg    = '{active: 1'b1, empty: 1'b1, default: 1'b0};
                        end else if (r_seg.active) begin
                            n_seg.empty = 1'b0;
                            if (!r_seg.nondigit && !r_seg.range) begin
                                if ((i_ctl.ch < CH_0) || (i_ctl.ch > CH_9)) begin
                                    n_seg.nondigit = 1'b1;
                                end else if (prod > {4'd0, PORT_MAX}) begin
                                    n_accum     = PORT_OVER;
                                    n_seg.range = 1'b1;
                                end else begin
                                    n_accum = prod[16:0];
                                end
                            end
                        end
                    end
                    BR_OPEN: begin
                        if (i_ctl.ch == CH_RBRK) begin
                            n_colon = i_ctl.pos;
                            n_br    = BR_CLOSED;
                        end
                    end
                    BR_CLOSED: begin
                        if (i_ctl.ch == CH_COLON) begin
                            n_br    = BR_PORT;
                            n_accum = '0;
                            n_seg   = '{active: 1'b1, empty: 1'b1, default: 1'b0};
                        end else begin
                            n_br = BR_BAD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (i_ctl.start) begin
            n_start = i_ctl.pos + t_pos'(1);
        end
    end

    // host/port split on the updated state
    always_comb begin
        if (n_seg.empty)         pcode = ERR_EMPTY_PORT;
        else if (n_seg.nondigit) pcode = ERR_PORT_CHAR;
        else if (n_seg.range)    pcode = ERR_PORT_RANGE;
        else if (n_accum == '0)  pcode = ERR_PORT_ZERO;
        else                     pcode = ERR_NONE;

        len         = i_ctl.fin_end - n_start;
        o_res.code  = ERR_NONE;
        o_res.given = 1'b0;
        o_res.first = n_start;
        o_res.count = len;
        o_res.port  = n_accum[15:0];

        if (len == '0) begin
            o_res.code = ERR_EMPTY_AUTH;
        end else if (n_at) begin
            o_res.code = ERR_USERINFO;
        end else if (n_br != BR_NONE) begin
            o_res.first = n_start + t_pos'(1);
            o_res.count = n_colon - n_start - t_pos'(1);
            if (n_br == BR_OPEN) begin
                o_res.code = ERR_OPEN_BRK;
            end else if (o_res.count == '0) begin
                o_res.code = ERR_EMPTY_HOST;
            end else if (n_br == BR_BAD) begin
                o_res.code = ERR_AFTER_BRK;
            end else if (n_br == BR_PORT) begin
                o_res.code  = pcode;
                o_res.given = 1'b1;
            end
        end else if (n_cvalid) begin
            o_res.count = n_colon - n_start;
            o_res.given = 1'b1;
            if (pcode != ERR_NONE) begin
                o_res.code = pcode;
            end else if (o_res.count == '0) begin
                o_res.code = ERR_EMPTY_HOST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.step && i_ctl.clear)) begin
            r_br     <= BR_NONE;
            r_seg    <= '0;
            r_accum  <= '0;
            r_start  <= '0;
            r_colon  <= '0;
            r_cvalid <= 1'b0;
            r_at     <= 1'b0;
        end else if (i_ctl.step) begin
            r_br     <= n_br;
            r_seg    <= n_seg;
            r_accum  <= n_accum;
            r_start  <= n_start;
            r_colon  <= n_colon;
            r_cvalid <= n_cvalid;
            r_at     <= n_at;
        end
    end

endmodule

FILE: rtl/core/url_stream_parser.sv
// URL byte parser. One byte per beat goes in, one tagged byte per beat comes out, at a sustained
// rate of one beat per cycle while i_stall is low; each byte passes an input register, then the
// result register. The beat flagged last carries the summary: first error by priority (too
// long above all), effective port (explicit, else 80 for http, 443 for https, else 0), the
// explicit-port flag, host offset and length, and the scheme kind. Summary fields read zero on
// other beats and, apart from the error code, whenever an error is reported. After the last
// beat the parser starts a fresh URL with the next byte.
module url_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_char_out,
    output logic [2:0]  o_byte_class,
    output logic        o_done_res,
    output logic [4:0]  o_error_code,
    output logic [15:0] o_port_number,
    output logic        o_port_given,
    output logic [15:0] o_host_first,
    output logic [15:0] o_host_count,
    output logic [1:0]  o_scheme_kind
);
    import usp_pkg::*;

    typedef enum logic [2:0] {
        PH_SCHEME,
        PH_SLASH1,
        PH_SLASH2,
        PH_AUTH,
        PH_PATH,
        PH_QUERY,
        PH_FRAG
    } t_phase;

    typedef struct packed {
        logic [2:0] cls;
        t_phase     ph;
    } t_tail;

    function automatic t_tail tail(input t_phase ph, input logic [7:0] ch);
        t_tail t;
        t.ph  = ph;
        if (ph == PH_FRAG) begin
            t.cls = CLS_FRAG;
        end else if (ch == CH_HASH) begin
            t.cls = CLS_DELIM;
            t.ph  = PH_FRAG;
        end else if (ph == PH_QUERY) begin
            t.cls = CLS_QUERY;
        end else if (ch == CH_QUEST) begin
            t.cls = CLS_DELIM;
            t.ph  = PH_QUERY;
        end else begin
            t.cls = CLS_PATH;
        end
        return t;
    endfunction

    // input stage
    logic        r_s1_valid;
    logic [7:0]  r_s1_char;
    logic        r_s1_last;

    // per-URL state
    t_phase      r_phase, n_phase;
    t_pos        r_pos,   n_pos;
    logic [1:0]  r_match, n_match;
    logic [15:0] r_flags, n_flags;
    logic [1:0]  r_kind,  n_kind;
    logic        r_given, n_given;
    t_pos        r_first, n_first;
    t_pos        r_count, n_count;

    // result stage
    logic        r_out_valid;
    logic [7:0]  r_char,  n_char;
    logic [2:0]  r_cls,   n_cls;
    logic        r_done;
    logic [4:0]  r_err,   n_err;
    logic [15:0] r_port,  n_port;
    logic        r_pgiven, n_pgiven;
    logic [15:0] r_hfirst, n_hfirst;
    logic [15:0] r_hcount, n_hcount;
    logic [1:0]  r_okind, n_okind;

    logic         adv;
    logic         accept;
    logic         term;
    logic         do_fin;
    t_tail        tl;
    t_scheme_info sch;
    t_auth_ctl    actl;
    t_auth_res    ares;

    assign adv     = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !adv;
    assign accept  = i_valid && !o_stall;

    assign term = (r_s1_char == CH_SLASH) || (r_s1_char == CH_QUEST) || (r_s1_char == CH_HASH);

    usp_scheme u_scheme (
        .i_ch    (r_s1_char),
        .i_pos   (r_pos),
        .i_match (r_match),
        .o_info  (sch)
    );

    always_comb begin
        actl.step    = adv;
        actl.ch      = r_s1_char;
        actl.pos     = r_pos;
        actl.feed    = (r_phase == PH_AUTH) && !term;
        actl.start   = (r_phase == PH_SLASH2) && (r_s1_char == CH_SLASH);
        actl.clear   = r_s1_last;
        actl.fin_end = ((r_phase == PH_AUTH) && term) ? r_pos : r_pos + t_pos'(1);
    end

    usp_authority u_authority (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (actl),
        .o_res   (ares)
    );

    always_comb begin
        n_phase = r_phase;
        n_match = r_match;
        n_flags = r_flags;
        n_kind  = r_kind;
        n_given = r_given;
        n_first = r_first;
        n_count = r_count;
        n_char  = r_s1_char;
        n_cls   = CLS_PATH;
        tl      = tail(PH_PATH, r_s1_char);

        // position saturates; hitting the top marks the URL too long
        if (r_pos == POS_MAX) begin
            n_pos      = r_pos;
            n_flags[0] = 1'b1;
        end else begin
            n_pos = r_pos + t_pos'(1);
        end

        if ((r_s1_char == CH_SPACE) || ((r_s1_char >= CH_TAB) && (r_s1_char <= CH_CR))) begin
            n_flags[ERR_SPACE[3:0]] = 1'b1;
        end

        case (r_phase)
            PH_SCHEME: begin
                if (r_s1_char == CH_COLON) begin
                    n_cls   = CLS_DELIM;
                    n_phase = PH_SLASH1;
                    if (r_pos == '0) begin
                        n_flags[ERR_EMPTY_SCH[3:0]] = 1'b1;
                    end
                    if ((r_pos == t_pos'(4)) && r_match[0]) begin
                        n_kind = KIND_HTTP;
                    end else if ((r_pos == t_pos'(5)) && r_match[1]) begin
                        n_kind = KIND_HTTPS;
                    end
                end else begin
                    n_cls   = CLS_SCHEME;
                    n_char  = sch.lower;
                    n_match = sch.match;
                    if (sch.bad_first) n_flags[ERR_SCH_FIRST[3:0]] = 1'b1;
                    if (sch.bad_char)  n_flags[ERR_SCH_CHAR[3:0]]  = 1'b1;
                end
            end
            PH_SLASH1, PH_SLASH2: begin
                if (r_s1_char == CH_SLASH) begin
                    n_cls   = CLS_DELIM;
                    n_phase = (r_phase == PH_SLASH1) ? PH_SLASH2 : PH_AUTH;
                end else begin
                    n_flags[ERR_NO_SLASHES[3:0]] = 1'b1;
                    n_cls   = tl.cls;
                    n_phase = tl.ph;
                end
            end
            PH_AUTH: begin
                if (term) begin
                    n_cls   = tl.cls;
                    n_phase = tl.ph;
                end else begin
                    n_cls = CLS_AUTH;
                end
            end
            default: begin
                tl      = tail(r_phase, r_s1_char);
                n_cls   = tl.cls;
                n_phase = tl.ph;
            end
        endcase

        // end-of-URL checks on the phase reached after this byte
        if (r_s1_last) begin
            if (n_phase == PH_SCHEME) begin
                n_flags[ERR_NO_SCHEME[3:0]] = 1'b1;
            end else if ((n_phase == PH_SLASH1) || (n_phase == PH_SLASH2)) begin
                n_flags[ERR_NO_SLASHES[3:0]] = 1'b1;
            end
        end

        // authority closes on its terminator or at the end of the URL, even if it just opened
        do_fin = ((r_phase == PH_AUTH) && term) || (r_s1_last && (n_phase == PH_AUTH));
        if (do_fin) begin
            if (ares.code != ERR_NONE) begin
                n_flags[ares.code[3:0]] = 1'b1;
            end else begin
                n_given = ares.given;
                n_first = ares.first;
                n_count = ares.count;
            end
        end

        n_err    = r_s1_last ? first_error(n_flags) : ERR_NONE;
        n_port   = '0;
        n_pgiven = 1'b0;
        n_hfirst = '0;
        n_hcount = '0;
        n_okind  = KIND_OTHER;
        if (r_s1_last && (n_err == ERR_NONE)) begin
            if (n_given) begin
                n_port = ares.port;
            end else if (n_kind == KIND_HTTP) begin
                n_port = PORT_HTTP;
            end else if (n_kind == KIND_HTTPS) begin
                n_port = PORT_HTTPS;
            end
            n_pgiven = n_given;
            n_hfirst = 16'(n_first);
            n_hcount = 16'(n_count);
            n_okind  = n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SCHEME;
            r_pos       <= '0;
            r_match     <= 2'b11;
            r_flags     <= '0;
            r_kind      <= KIND_OTHER;
            r_given     <= 1'b0;
            r_first     <= '0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_char  <= i_char_in;
                r_s1_last  <= i_is_last;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
                r_char      <= n_char;
                r_cls       <= n_cls;
                r_done      <= r_s1_last;
                r_err       <= n_err;
                r_port      <= n_port;
                r_pgiven    <= n_pgiven;
                r_hfirst    <= n_hfirst;
                r_hcount    <= n_hcount;
                r_okind     <= n_okind;
                if (r_s1_last) begin
                    r_phase <= PH_SCHEME;
                    r_pos   <= '0;
                    r_match <= 2'b11;
                    r_flags <= '0;
                    r_kind  <= KIND_OTHER;
                    r_given <= 1'b0;
                    r_first <= '0;
                    r_count <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_match <= n_match;
                    r_flags <= n_flags;
                    r_kind  <= n_kind;
                    r_given <= n_given;
                    r_first <= n_first;
                    r_count <= n_count;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_char_out    = r_char;
    assign o_byte_class  = r_cls;
    assign o_done_res    = r_done;
    assign o_error_code  = r_err;
    assign o_port_number = r_port;
    assign o_port_given  = r_pgiven;
    assign o_host_first  = r_hfirst;
    assign o_host_count  = r_hcount;
    assign o_scheme_kind = r_okind;

endmodule
